>>> rtl/core/fcgidfr_pkg.sv
`timescale 1ns / 1ps

package fcgidfr_pkg;

  // Record types handled by the deframer
  localparam logic [7:0] KIND_PARAMS = 8'd4;
  localparam logic [7:0] KIND_STDIN  = 8'd5;

  // Header byte positions
  localparam logic [2:0] HDR_KIND     = 3'd1;
  localparam logic [2:0] HDR_IDENT_HI = 3'd2;
  localparam logic [2:0] HDR_IDENT_LO = 3'd3;
  localparam logic [2:0] HDR_LEN_HI   = 3'd4;
  localparam logic [2:0] HDR_LEN_LO   = 3'd5;
  localparam logic [2:0] HDR_PAD      = 3'd6;
  localparam logic [2:0] HDR_LAST     = 3'd7;

  // A long length takes this many bytes after its first one
  localparam logic [1:0] LONG_LEN_MORE = 2'd3;
  localparam logic [6:0] LEN_MASK      = 7'h7f;

  localparam int LEN_W = 31;

  typedef enum logic [2:0] {
    ROLE_NAME  = 3'd0,
    ROLE_VALUE = 3'd1,
    ROLE_BODY  = 3'd2,
    ROLE_EMPTY = 3'd3,
    ROLE_PEND  = 3'd4,
    ROLE_SEND  = 3'd5,
    ROLE_TRUNC = 3'd6
  } role_t;

  typedef enum logic [2:0] {
    PH_NLEN      = 3'd0,
    PH_NLEN_MORE = 3'd1,
    PH_VLEN      = 3'd2,
    PH_VLEN_MORE = 3'd3,
    PH_NAME      = 3'd4,
    PH_VALUE     = 3'd5,
    PH_DROP      = 3'd6
  } phase_t;

  typedef struct packed {
    logic        valid;
    logic [7:0]  data;
    role_t       role;
    logic        pend;
    logic [15:0] ident;
    logic        done;
  } result_t;

endpackage

>>> rtl/core/fcgidfr_core.sv
`timescale 1ns / 1ps

// Deframer state and the per-byte step. One byte per step, result is combinational.
module fcgidfr_core (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    step,
  input  logic [7:0]              b,
  output fcgidfr_pkg::result_t    res
);

  logic [2:0]                    header_count, header_count_next;
  logic [7:0]                    record_kind, record_kind_next;
  logic [15:0]                   record_ident, record_ident_next;
  logic [15:0]                   content_left, content_left_next;
  logic [7:0]                    padding_left, padding_left_next;
  fcgidfr_pkg::phase_t           pair_phase, pair_phase_next;
  logic [1:0]                    length_bytes_left, length_bytes_left_next;
  logic [fcgidfr_pkg::LEN_W-1:0] length_accum, length_accum_next;
  logic [fcgidfr_pkg::LEN_W-1:0] name_left, name_left_next;
  logic [fcgidfr_pkg::LEN_W-1:0] value_left, value_left_next;
  logic                          params_seen_end, params_seen_end_next;
  logic                          stdin_seen_end, stdin_seen_end_next;
  logic [15:0]                   held_ident, held_ident_next;

  logic                          is_header;
  logic [15:0]                   rem;
  logic                          len_complete;
  logic                          is_name;
  logic                          trunc;
  logic                          done;
  logic [fcgidfr_pkg::LEN_W-1:0] len_val;
  logic [fcgidfr_pkg::LEN_W:0]   pair_total;
  logic [1:0]                    lbl_dec;

  always_comb begin
    header_count_next      = header_count;
    record_kind_next       = record_kind;
    record_ident_next      = record_ident;
    content_left_next      = content_left;
    padding_left_next      = padding_left;
    pair_phase_next        = pair_phase;
    length_bytes_left_next = length_bytes_left;
    length_accum_next      = length_accum;
    name_left_next         = name_left;
    value_left_next        = value_left;
    params_seen_end_next   = params_seen_end;
    stdin_seen_end_next    = stdin_seen_end;
    held_ident_next        = held_ident;

    res          = '0;
    res.role     = fcgidfr_pkg::ROLE_NAME;
    len_complete = 1'b0;
    trunc        = 1'b0;
    done         = 1'b0;
    len_val      = '0;
    pair_total   = '0;
    lbl_dec      = length_bytes_left - 2'd1;
    is_name      = (pair_phase == fcgidfr_pkg::PH_NLEN) ||
                   (pair_phase == fcgidfr_pkg::PH_NLEN_MORE);
    rem          = content_left - 16'd1;
    is_header    = (header_count != 3'd0) || (content_left == 16'd0 && padding_left == 8'd0);

    if (is_header) begin
      header_count_next = header_count + 3'd1;
      unique case (header_count)
        fcgidfr_pkg::HDR_KIND:     record_kind_next = b;
        fcgidfr_pkg::HDR_IDENT_HI: record_ident_next = {b, 8'd0};
        fcgidfr_pkg::HDR_IDENT_LO: record_ident_next = {record_ident[15:8], b};
        fcgidfr_pkg::HDR_LEN_HI:   content_left_next = {b, 8'd0};
        fcgidfr_pkg::HDR_LEN_LO:   content_left_next = {content_left[15:8], b};
        fcgidfr_pkg::HDR_PAD:      padding_left_next = b;
        fcgidfr_pkg::HDR_LAST: begin
          pair_phase_next        = fcgidfr_pkg::PH_NLEN;
          length_bytes_left_next = 2'd0;
          length_accum_next      = '0;
          name_left_next         = '0;
          value_left_next        = '0;
          if (held_ident == 16'd0) begin
            held_ident_next = record_ident;
          end
          if (content_left == 16'd0 &&
              (record_kind == fcgidfr_pkg::KIND_PARAMS ||
               record_kind == fcgidfr_pkg::KIND_STDIN)) begin
            if (record_kind == fcgidfr_pkg::KIND_PARAMS) begin
              params_seen_end_next = 1'b1;
              res.role             = fcgidfr_pkg::ROLE_PEND;
            end else begin
              stdin_seen_end_next  = 1'b1;
              res.role             = fcgidfr_pkg::ROLE_SEND;
            end
            done      = params_seen_end_next && stdin_seen_end_next;
            res.valid = 1'b1;
            res.done  = done;
            res.ident = held_ident_next;
            if (done) begin
              params_seen_end_next = 1'b0;
              stdin_seen_end_next  = 1'b0;
              held_ident_next      = 16'd0;
            end
          end
        end
        default: ;
      endcase
    end else if (content_left != 16'd0) begin
      content_left_next = rem;
      if (record_kind == fcgidfr_pkg::KIND_PARAMS) begin
        unique case (pair_phase)
          fcgidfr_pkg::PH_NLEN, fcgidfr_pkg::PH_VLEN: begin
            if (b[7]) begin
              if (rem < 16'd3) begin
                trunc = 1'b1;
              end else begin
                length_accum_next      = {24'd0, b[6:0] & fcgidfr_pkg::LEN_MASK};
                length_bytes_left_next = fcgidfr_pkg::LONG_LEN_MORE;
                pair_phase_next        = (pair_phase == fcgidfr_pkg::PH_NLEN) ?
                                         fcgidfr_pkg::PH_NLEN_MORE :
                                         fcgidfr_pkg::PH_VLEN_MORE;
              end
            end else begin
              len_val           = {23'd0, b};
              length_accum_next = len_val;
              len_complete      = 1'b1;
            end
          end
          fcgidfr_pkg::PH_NLEN_MORE, fcgidfr_pkg::PH_VLEN_MORE: begin
            len_val                = {length_accum[22:0], b};
            length_accum_next      = len_val;
            length_bytes_left_next = lbl_dec;
            len_complete           = (lbl_dec == 2'd0);
          end
          fcgidfr_pkg::PH_NAME: begin
            name_left_next = name_left - 31'd1;
            res.valid      = 1'b1;
            res.data       = b;
            res.role       = fcgidfr_pkg::ROLE_NAME;
            res.ident      = held_ident;
            if (name_left_next == '0) begin
              if (value_left == '0) begin
                pair_phase_next = fcgidfr_pkg::PH_NLEN;
                res.pend        = 1'b1;
              end else begin
                pair_phase_next = fcgidfr_pkg::PH_VALUE;
              end
            end
          end
          fcgidfr_pkg::PH_VALUE: begin
            value_left_next = value_left - 31'd1;
            res.valid       = 1'b1;
            res.data        = b;
            res.role        = fcgidfr_pkg::ROLE_VALUE;
            res.ident       = held_ident;
            if (value_left_next == '0) begin
              pair_phase_next = fcgidfr_pkg::PH_NLEN;
              res.pend        = 1'b1;
            end
          end
          default: ;
        endcase

        if (len_complete) begin
          if (is_name) begin
            name_left_next  = len_val;
            pair_phase_next = fcgidfr_pkg::PH_VLEN;
            trunc           = (rem == 16'd0);
          end else begin
            value_left_next = len_val;
            pair_total      = {1'b0, name_left} + {1'b0, len_val};
            if (pair_total > {16'd0, rem}) begin
              trunc = 1'b1;
            end else if (name_left == '0 && len_val == '0) begin
              pair_phase_next = fcgidfr_pkg::PH_NLEN;
              res.valid       = 1'b1;
              res.role        = fcgidfr_pkg::ROLE_EMPTY;
              res.pend        = 1'b1;
              res.ident       = held_ident;
            end else begin
              pair_phase_next = (name_left != '0) ? fcgidfr_pkg::PH_NAME :
                                                    fcgidfr_pkg::PH_VALUE;
            end
          end
        end

        if (trunc) begin
          pair_phase_next        = fcgidfr_pkg::PH_DROP;
          length_bytes_left_next = 2'd0;
          res.valid              = 1'b1;
          res.data               = 8'd0;
          res.role               = fcgidfr_pkg::ROLE_TRUNC;
          res.pend               = 1'b0;
          res.ident              = held_ident;
        end
      end else if (record_kind == fcgidfr_pkg::KIND_STDIN) begin
        res.valid = 1'b1;
        res.data  = b;
        res.role  = fcgidfr_pkg::ROLE_BODY;
        res.ident = held_ident;
      end
    end else begin
      padding_left_next = padding_left - 8'd1;
    end

    if (!step) begin
      res.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_count      <= 3'd0;
      record_kind       <= 8'd0;
      record_ident      <= 16'd0;
      content_left      <= 16'd0;
      padding_left      <= 8'd0;
      pair_phase        <= fcgidfr_pkg::PH_NLEN;
      length_bytes_left <= 2'd0;
      length_accum      <= '0;
      name_left         <= '0;
      value_left        <= '0;
      params_seen_end   <= 1'b0;
      stdin_seen_end    <= 1'b0;
      held_ident        <= 16'd0;
    end else if (step) begin
      header_count      <= header_count_next;
      record_kind       <= record_kind_next;
      record_ident      <= record_ident_next;
      content_left      <= content_left_next;
      padding_left      <= padding_left_next;
      pair_phase        <= pair_phase_next;
      length_bytes_left <= length_bytes_left_next;
      length_accum      <= length_accum_next;
      name_left         <= name_left_next;
      value_left        <= value_left_next;
      params_seen_end   <= params_seen_end_next;
      stdin_seen_end    <= stdin_seen_end_next;
      held_ident        <= held_ident_next;
    end
  end

endmodule

>>> rtl/core/fastcgi_record_deframer_unit.sv
`timescale 1ns / 1ps

// Byte-serial FastCGI request deframer. One connection byte is taken per
// request on the input channel; each byte produces at most one result on the
// output channel (name/value/body bytes, empty-pair, end and truncation marks).
// Throughput is one byte per clock while the output is not stalled: a byte is
// held in the input register, is parsed by the single-step logic of the core,
// and its result (if any) is registered in the output register, from which it
// is offered.
// The input stalls only when the output register is full and not being taken.
// Record headers (but for the end mark of an empty params or stdin record),
// padding, and records of other types give no result. request_done rises on
// the end mark that completes a request; the held request id and the end flags are then cleared for the next request.
module fastcgi_record_deframer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  stream_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  data_byte,
  output logic [2:0]  role,
  output logic        pair_end,
  output logic [15:0] request_ident,
  output logic        request_done
);

  logic                 hold_valid;
  logic [7:0]           hold_byte;
  logic                 proc;
  fcgidfr_pkg::result_t res;
  fcgidfr_pkg::result_t out_q;

  // Parse the held byte when the output slot is free or draining this cycle.
  assign proc     = hold_valid && (!out_valid || out_ready);
  assign in_ready = !hold_valid || proc;

  fcgidfr_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (proc),
    .b    (hold_byte),
    .res  (res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      hold_byte <= stream_byte;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc && res.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (proc && res.valid) begin
      out_q <= res;
    end
  end

  assign data_byte     = out_q.data;
  assign role          = out_q.role;
  assign pair_end      = out_q.pend;
  assign request_ident = out_q.ident;
  assign request_done  = out_q.done;

endmodule
